@@ hdl/utrd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utrd_pkg: shared types and constants for unsigned_to_radix_digits
// Holds the controller/datapath command and status structs, the alphabet
// rules and the register indexes of the configuration port.
// ----------------------------------------------------------------------------
package utrd_pkg;

  // value and alphabet geometry
  localparam int VALUE_W   = 64;
  localparam int CHAR_W    = 8;
  localparam int ALPHA_N   = 16;
  localparam int DIGIT_W   = 4;
  localparam int RADIX_W   = 5;
  localparam int CFG_IDX_W = 2;

  // alphabet rules
  localparam logic [RADIX_W-1:0] MIN_RADIX = 5'd2;
  localparam logic [RADIX_W-1:0] MAX_RADIX = 5'd16;
  localparam logic [CHAR_W-1:0]  CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0]  CHAR_MINUS = 8'h2D;

  // divider: quotient bits retired per cycle, cycles per digit
  localparam int BITS_PER_STEP   = 4;
  localparam int STEPS_PER_DIGIT = VALUE_W / BITS_PER_STEP;
  localparam int STEP_CNT_W      = $clog2(STEPS_PER_DIGIT);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIX_LEN  = 2'd2;

  // reset contents: "0123456789ABCDEF", radix ten
  localparam logic [VALUE_W-1:0] ALPHA_LOW_RST  = 64'h3736353433323130;
  localparam logic [VALUE_W-1:0] ALPHA_HIGH_RST = 64'h4645444342413938;
  localparam logic [RADIX_W-1:0] RADIX_LEN_RST  = 5'd10;

  // controller to datapath
  typedef struct packed {
    logic load;     // take a new value, clear the digit count
    logic step;     // one divider step
    logic finish;   // last divider cycle of a digit: store the remainder
    logic emit;     // read one stored digit toward the output
    logic err;      // send the bad alphabet result
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic alpha_ok;  // alphabet and radix pass the checks
    logic div_done;  // this digit is the last one to compute
    logic rd_zero;   // read pointer is at the least significant digit
  } sts_t;

endpackage

@@ hdl/utrd_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utrd_ctrl: sequencer for unsigned_to_radix_digits
// Walks each item through the divide phase (all divider steps of each digit)
// and the emit phase (one stored digit per cycle), or flags a bad alphabet.
// ----------------------------------------------------------------------------
module utrd_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  utrd_pkg::sts_t  sts,
  output utrd_pkg::cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_DIVIDE = 2'd1;
  localparam logic [1:0] ST_EMIT   = 2'd2;

  localparam logic [utrd_pkg::STEP_CNT_W-1:0] STEP_LAST =
    utrd_pkg::STEP_CNT_W'(utrd_pkg::STEPS_PER_DIGIT - 1);

  logic [1:0]                      state;
  logic [1:0]                      state_next;
  logic [utrd_pkg::STEP_CNT_W-1:0] step_cnt;
  logic [utrd_pkg::STEP_CNT_W-1:0] step_cnt_next;

  assign busy = (state != ST_IDLE);

  // next state and commands
  always_comb begin
    state_next    = state;
    step_cnt_next = step_cnt;
    cmd           = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          if (sts.alpha_ok) begin
            cmd.load      = 1'b1;
            step_cnt_next = '0;
            state_next    = ST_DIVIDE;
          end else begin
            cmd.err = 1'b1;
          end
        end
      end
      ST_DIVIDE: begin
        cmd.step = 1'b1;
        if (step_cnt == STEP_LAST) begin
          cmd.finish    = 1'b1;
          step_cnt_next = '0;
          if (sts.div_done) begin
            state_next = ST_EMIT;
          end
        end else begin
          step_cnt_next = step_cnt + utrd_pkg::STEP_CNT_W'(1);
        end
      end
      ST_EMIT: begin
        cmd.emit = 1'b1;
        if (sts.rd_zero) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      step_cnt <= '0;
    end else begin
      state    <= state_next;
      step_cnt <= step_cnt_next;
    end
  end

endmodule

@@ hdl/utrd_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utrd_dp: datapath for unsigned_to_radix_digits
// Configuration registers, alphabet checker, radix-r divider retiring four
// quotient bits a cycle, digit store and the registered output beat.
// ----------------------------------------------------------------------------
module utrd_dp #(
  parameter int MAX_DIGITS = 64
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic [utrd_pkg::VALUE_W-1:0]          value,
  input  logic                                  cfg_we,
  input  logic [utrd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [utrd_pkg::VALUE_W-1:0]          cfg_data,
  input  utrd_pkg::cmd_t                        cmd,
  output utrd_pkg::sts_t                        sts,
  output logic                                  strobe,
  output logic [utrd_pkg::CHAR_W-1:0]           digit_char,
  output logic                                  last_digit,
  output logic                                  bad_alphabet
);

  localparam int AW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int CW = $clog2(MAX_DIGITS + 1);

  // configuration registers
  logic [utrd_pkg::VALUE_W-1:0] alpha_low;
  logic [utrd_pkg::VALUE_W-1:0] alpha_high;
  logic [utrd_pkg::RADIX_W-1:0] radix_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_low  <= utrd_pkg::ALPHA_LOW_RST;
      alpha_high <= utrd_pkg::ALPHA_HIGH_RST;
      radix_len  <= utrd_pkg::RADIX_LEN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        utrd_pkg::REG_ALPHA_LOW:  alpha_low  <= cfg_data;
        utrd_pkg::REG_ALPHA_HIGH: alpha_high <= cfg_data;
        utrd_pkg::REG_RADIX_LEN:  radix_len  <= cfg_data[utrd_pkg::RADIX_W-1:0];
        default: ;
      endcase
    end
  end

  // alphabet as byte lanes
  logic [utrd_pkg::ALPHA_N-1:0][utrd_pkg::CHAR_W-1:0] alpha;
  assign alpha = {alpha_high, alpha_low};

  // alphabet check: length, forbidden bytes, duplicates among lanes in use
  logic [utrd_pkg::ALPHA_N-1:0] lane_bad;
  logic                         len_bad;
  logic                         dup_bad;

  always_comb begin
    for (int a = 0; a < utrd_pkg::ALPHA_N; a++) begin
      lane_bad[a] = (utrd_pkg::RADIX_W'(a) < radix_len) &&
                    ((alpha[a] == '0) ||
                     (alpha[a] == utrd_pkg::CHAR_PLUS) ||
                     (alpha[a] == utrd_pkg::CHAR_MINUS));
    end
  end

  always_comb begin
    dup_bad = 1'b0;
    for (int a = 0; a < utrd_pkg::ALPHA_N; a++) begin
      for (int b = a + 1; b < utrd_pkg::ALPHA_N; b++) begin
        if ((utrd_pkg::RADIX_W'(b) < radix_len) && (alpha[a] == alpha[b])) begin
          dup_bad = 1'b1;
        end
      end
    end
  end

  assign len_bad      = (radix_len < utrd_pkg::MIN_RADIX) ||
                        (radix_len > utrd_pkg::MAX_RADIX);
  assign sts.alpha_ok = !len_bad && !dup_bad && !(|lane_bad);

  // divider state
  logic [utrd_pkg::VALUE_W-1:0] quo;
  logic [utrd_pkg::DIGIT_W-1:0] rem;
  logic [CW-1:0]                ndig;
  logic [AW-1:0]                rd_ptr;

  // four restoring steps: remainder stays below the radix
  logic [utrd_pkg::VALUE_W-1:0] quo_step;
  logic [utrd_pkg::DIGIT_W-1:0] rem_step;
  logic [utrd_pkg::RADIX_W-1:0] trial;

  always_comb begin
    quo_step = quo;
    rem_step = rem;
    trial    = '0;
    for (int i = 0; i < utrd_pkg::BITS_PER_STEP; i++) begin
      trial    = {rem_step, quo_step[utrd_pkg::VALUE_W-1]};
      quo_step = {quo_step[utrd_pkg::VALUE_W-2:0], 1'b0};
      if (trial >= radix_len) begin
        rem_step    = utrd_pkg::DIGIT_W'(trial - radix_len);
        quo_step[0] = 1'b1;
      end else begin
        rem_step = trial[utrd_pkg::DIGIT_W-1:0];
      end
    end
  end

  logic [CW-1:0] ndig_inc;
  assign ndig_inc     = ndig + CW'(1);
  assign sts.div_done = (quo_step == '0) || (ndig_inc == CW'(MAX_DIGITS));
  assign sts.rd_zero  = (rd_ptr == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      quo    <= '0;
      rem    <= '0;
      ndig   <= '0;
      rd_ptr <= '0;
    end else if (cmd.load) begin
      quo  <= value;
      rem  <= '0;
      ndig <= '0;
    end else if (cmd.finish) begin
      quo  <= quo_step;
      rem  <= '0;
      ndig <= ndig_inc;
      if (sts.div_done) begin
        rd_ptr <= ndig[AW-1:0];
      end
    end else if (cmd.step) begin
      quo <= quo_step;
      rem <= rem_step;
    end else if (cmd.emit) begin
      rd_ptr <= rd_ptr - AW'(1);
    end
  end

  // digit store, least significant digit at entry zero
  logic [utrd_pkg::DIGIT_W-1:0] digit_mem [MAX_DIGITS];
  logic [utrd_pkg::DIGIT_W-1:0] rd_data;

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      digit_mem[ndig[AW-1:0]] <= rem_step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      rd_data <= digit_mem[rd_ptr];
    end
  end

  // output beat flags
  logic out_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe     <= 1'b0;
      out_err    <= 1'b0;
      last_digit <= 1'b0;
    end else begin
      strobe     <= cmd.emit || cmd.err;
      out_err    <= cmd.err;
      last_digit <= cmd.err || (cmd.emit && sts.rd_zero);
    end
  end

  // character lookup on the registered digit
  assign bad_alphabet = out_err;
  assign digit_char   = out_err ? '0 : alpha[rd_data];

endmodule

@@ hdl/unsigned_to_radix_digits.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unsigned_to_radix_digits: 64-bit unsigned value to radix digit characters
// Emits the digits most significant first, one beat per digit, using a
// configurable alphabet of up to sixteen bytes; a bad alphabet gives a
// single error beat.
// ----------------------------------------------------------------------------
//
//  channel   | handshake                | payload
//  ----------+--------------------------+----------------------------------
//  input     | start in, busy out       | value
//  result    | strobe out (no stall)    | digit_char, last_digit, bad_alphabet
//  config    | cfg_valid in, cfg_ready  | cfg_index, cfg_data
//
//  An item passes each digit through the divider (four quotient bits a
//  cycle over 64 bits), then reads the digit store one digit per cycle.
//  A bad alphabet gives its error beat in the cycle after start and busy stays low.
//  Reset restores the alphabet "0123456789ABCDEF" with radix ten.
//  Results are shown for one cycle each; the receiver cannot stall them.
//
module unsigned_to_radix_digits #(
  parameter int MAX_DIGITS = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [utrd_pkg::VALUE_W-1:0]       value,
  output logic                               strobe,
  output logic [utrd_pkg::CHAR_W-1:0]        digit_char,
  output logic                               last_digit,
  output logic                               bad_alphabet,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [utrd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [utrd_pkg::VALUE_W-1:0]       cfg_data
);

  utrd_pkg::cmd_t cmd;
  utrd_pkg::sts_t sts;

  // registers take a write in any cycle
  assign cfg_ready = 1'b1;

  utrd_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  utrd_dp #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .value        (value),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .sts          (sts),
    .strobe       (strobe),
    .digit_char   (digit_char),
    .last_digit   (last_digit),
    .bad_alphabet (bad_alphabet)
  );

endmodule
